// ===== sv/blpg_pkg.sv =====
`default_nettype none

package blpg_pkg;

    // coordinate width of every endpoint and pixel field
    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 16;

    // request command codes
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_command;

    // input request payload
    typedef struct packed {
        t_command                      command;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
        logic        [COLOR_BITS-1:0]  color;
    } t_in_item;

    // output pixel payload
    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic        [COLOR_BITS-1:0]  pixel_color;
        logic                          pixel_valid;
        logic                          last;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load_start;
        logic do_step;
        logic finish_setup;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== sv/blpg_ctrl.sv =====
`default_nettype none

module blpg_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire blpg_pkg::t_command i_command,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output blpg_pkg::t_dp_cmd       o_cmd
);
    import blpg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SETUP = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   load_out;

    // accept only in idle, when the output slot is empty or draining this cycle
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // datapath commands
    always_comb begin
        o_cmd.load_start   = accept && (i_command == CMD_START);
        o_cmd.do_step      = accept && (i_command == CMD_STEP);
        o_cmd.finish_setup = (r_state == S_SETUP);
    end

    assign load_out = o_cmd.do_step || o_cmd.finish_setup;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load_start) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output slot occupancy
    assign n_out_valid = load_out || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== sv/blpg_datapath.sv =====
`default_nettype none

module blpg_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire blpg_pkg::t_in_item  i_in_data,
    input  wire blpg_pkg::t_dp_cmd   i_cmd,
    output blpg_pkg::t_out_item      o_out_data
);
    import blpg_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;

    // line state
    logic signed [W-1:0]  r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic signed [DW-1:0] r_dx, r_dy;
    logic                 r_x_neg, r_y_neg, r_x_major, r_active;
    logic signed [EW-1:0] r_err, r_inc_neg, r_inc_pos;
    logic [COLOR_BITS-1:0] r_color;
    t_out_item            r_out, n_out;

    // start: ordered endpoints
    logic                 swap_x, swap_y;
    logic signed [W-1:0]  x1, x2, y1, y2;

    // setup: magnitudes and error terms
    logic [DW-1:0]        neg_dx, neg_dy;
    logic [W-1:0]         abs_dx, abs_dy;
    logic                 major;
    logic signed [EW-1:0] tw_dx, tw_dy, err_init, inc_xm, inc_ym;
    logic                 setup_last;

    // step: next position
    logic signed [W-1:0]  x_inc, y_inc, nx, ny;
    logic                 err_neg, step_last;

    // endpoint ordering for horizontal and vertical lines
    always_comb begin
        swap_y = (i_in_data.start_x == i_in_data.end_x) &&
                 (i_in_data.start_y > i_in_data.end_y);
        swap_x = (i_in_data.start_y == i_in_data.end_y) &&
                 (i_in_data.start_x > i_in_data.end_x);
        x1 = swap_x ? i_in_data.end_x   : i_in_data.start_x;
        x2 = swap_x ? i_in_data.start_x : i_in_data.end_x;
        y1 = swap_y ? i_in_data.end_y   : i_in_data.start_y;
        y2 = swap_y ? i_in_data.start_y : i_in_data.end_y;
    end

    // slope setup from the stored deltas
    always_comb begin
        neg_dx   = -r_dx;
        neg_dy   = -r_dy;
        abs_dx   = r_dx[DW-1] ? neg_dx[W-1:0] : r_dx[W-1:0];
        abs_dy   = r_dy[DW-1] ? neg_dy[W-1:0] : r_dy[W-1:0];
        major    = (abs_dx >= abs_dy);
        tw_dx    = $signed({2'b00, abs_dx, 1'b0});
        tw_dy    = $signed({2'b00, abs_dy, 1'b0});
        err_init = major ? (tw_dy - $signed({3'b000, abs_dx}))
                         : (tw_dx - $signed({3'b000, abs_dy}));
        inc_xm   = tw_dy - tw_dx;
        inc_ym   = tw_dx - tw_dy;
        setup_last = major ? (r_cur_x == r_tgt_x) : (r_cur_y == r_tgt_y);
    end

    // one bresenham step
    always_comb begin
        x_inc   = r_cur_x + (r_x_neg ? {W{1'b1}} : W'(1));
        y_inc   = r_cur_y + (r_y_neg ? {W{1'b1}} : W'(1));
        err_neg = r_err[EW-1];
        if (r_x_major) begin
            nx = x_inc;
            ny = err_neg ? r_cur_y : y_inc;
        end else begin
            ny = y_inc;
            nx = err_neg ? r_cur_x : x_inc;
        end
        step_last = r_x_major ? (nx == r_tgt_x) : (ny == r_tgt_y);
    end

    // output pixel selection
    always_comb begin
        n_out = r_out;
        if (i_cmd.finish_setup) begin
            n_out.pixel_x     = r_cur_x;
            n_out.pixel_y     = r_cur_y;
            n_out.pixel_color = r_color;
            n_out.pixel_valid = 1'b1;
            n_out.last        = setup_last;
        end else if (i_cmd.do_step) begin
            if (r_active) begin
                n_out.pixel_x     = nx;
                n_out.pixel_y     = ny;
                n_out.pixel_color = r_color;
                n_out.pixel_valid = 1'b1;
                n_out.last        = step_last;
            end else begin
                n_out = '0;
            end
        end
    end

    // line payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_cmd.load_start) begin
            r_cur_x <= x1;
            r_cur_y <= y1;
            r_tgt_x <= x2;
            r_tgt_y <= y2;
            r_dx    <= {x2[W-1], x2} - {x1[W-1], x1};
            r_dy    <= {y2[W-1], y2} - {y1[W-1], y1};
            r_color <= i_in_data.color;
        end else if (i_cmd.finish_setup) begin
            r_x_neg   <= r_dx[DW-1];
            r_y_neg   <= r_dy[DW-1];
            r_x_major <= major;
            r_err     <= err_init;
            r_inc_pos <= major ? tw_dy : tw_dx;
            r_inc_neg <= major ? inc_xm : inc_ym;
        end else if (i_cmd.do_step && r_active) begin
            r_cur_x <= nx;
            r_cur_y <= ny;
            r_err   <= r_err + (err_neg ? r_inc_pos : r_inc_neg);
        end
    end

    // line activity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.finish_setup) begin
            r_active <= !setup_last;
        end else if (i_cmd.do_step && r_active && step_last) begin
            r_active <= 1'b0;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

// ===== sv/bresenham_line_pixel_generator_unit.sv =====
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+---------------------
// in        | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
// out       | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
// a step pixel is registered; steps run one per clock while the output drains
// a start request runs delta capture, then the slope setup register stage
// the output register frees the input side as soon as the held pixel is taken
// a stalled output holds its pixel and blocks new requests until taken
// synchronous active-low reset clears the controller and any active line
`default_nettype none

module bresenham_line_pixel_generator_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire blpg_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output blpg_pkg::t_out_item      o_out_data
);
    import blpg_pkg::*;

    t_dp_cmd dp_cmd;

    // sequencing and handshake control
    blpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in_data.command),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd)
    );

    // line state and pixel arithmetic
    blpg_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

// ===== sv/blpg_checker.sv =====
`default_nettype none

module blpg_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                o_in_ready,
    input  wire blpg_pkg::t_in_item  i_in_data,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_ready,
    input  wire blpg_pkg::t_out_item o_out_data
);
    import blpg_pkg::*;

    logic start_acc, step_acc;

    assign start_acc = i_in_valid && o_in_ready && (i_in_data.command == CMD_START);
    assign step_acc  = i_in_valid && o_in_ready && (i_in_data.command == CMD_STEP);

    // a stalled pixel holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output pixel changed while stalled");

    // a step request yields a result, possibly empty, on the next cycle
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_acc |=> o_out_valid)
        else $error("step request gave no result");

    // a start request blocks for setup and then yields its first pixel
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_acc |=> !o_in_ready ##1 (o_out_valid && o_out_data.pixel_valid))
        else $error("start request sequencing broken");

    // an empty result carries all-zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.pixel_valid |->
            o_out_data.pixel_x == '0 && o_out_data.pixel_y == '0 &&
            o_out_data.pixel_color == '0 && !o_out_data.last)
        else $error("empty result has nonzero fields");

endmodule

bind bresenham_line_pixel_generator_unit blpg_checker u_blpg_checker (.*);

`default_nettype wire

// ===== tb/bresenham_line_pixel_generator_unit_tb.sv =====
`timescale 1ns / 1ps

module bresenham_line_pixel_generator_unit_tb;

    import blpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_ITEMS    = 250;
    localparam int NUM_PHASES     = 5;
    localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
    localparam t_out_item NO_PIXEL = '0;

    // one row of the directed stimulus, with an optional hand-written pixel
    typedef struct packed {
        t_in_item  req;
        logic      typed;
        t_out_item px;
    } t_plan_row;

    typedef struct packed {
        logic      typed;
        t_out_item px;
    } t_note;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_plan[NUM_PHASES]  = '{0, 70, 0, 24, 0};
    int stall_plan[NUM_PHASES] = '{0, 0, 70, 24, 0};

    t_out_item pixel_queue[$];
    t_note     note_queue[$];
    int        fail_cnt = 0;
    int        sent_cnt = 0;
    int        start_cnt = 0;
    int        step_cnt = 0;
    int        checked_cnt = 0;
    int        blank_cnt = 0;
    int        last_cnt = 0;
    int        quiet_cycles = 0;

    // predictor copy of the line walker
    int   pen_x = 0, pen_y = 0, goal_x = 0, goal_y = 0;
    bit   x_neg = 0, y_neg = 0, x_major = 0, drawing = 0;
    int   two_dx = 0, two_dy = 0, err_acc = 0;
    logic [COLOR_BITS-1:0] ink = '0;

    bresenham_line_pixel_generator_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // next pixel of the line for one accepted request
    function automatic t_out_item predict_pixel(t_in_item req);
        int x1, y1, x2, y2, dx, dy, t;
        t_out_item px;
        px = NO_PIXEL;
        if (req.command == CMD_START) begin
            x1 = req.start_x;
            y1 = req.start_y;
            x2 = req.end_x;
            y2 = req.end_y;
            ink = req.color;
            // axis-aligned lines always walk upward
            if (x1 == x2 && y1 > y2) begin
                t = y1; y1 = y2; y2 = t;
            end
            if (y1 == y2 && x1 > x2) begin
                t = x1; x1 = x2; x2 = t;
            end
            dx = x2 - x1;
            dy = y2 - y1;
            x_neg = dx < 0;
            y_neg = dy < 0;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            two_dx = 2 * dx;
            two_dy = 2 * dy;
            x_major = dx >= dy;
            err_acc = x_major ? (two_dy - dx) : (two_dx - dy);
            pen_x = x1;
            pen_y = y1;
            goal_x = x2;
            goal_y = y2;
            drawing = 1'b1;
        end else begin
            if (!drawing) return px;
            if (x_major) begin
                pen_x += x_neg ? -1 : 1;
                if (err_acc < 0) begin
                    err_acc += two_dy;
                end else begin
                    err_acc += two_dy - two_dx;
                    pen_y += y_neg ? -1 : 1;
                end
            end else begin
                pen_y += y_neg ? -1 : 1;
                if (err_acc < 0) begin
                    err_acc += two_dx;
                end else begin
                    err_acc += two_dx - two_dy;
                    pen_x += x_neg ? -1 : 1;
                end
            end
        end
        px.pixel_x     = COORD_BITS'(pen_x);
        px.pixel_y     = COORD_BITS'(pen_y);
        px.pixel_color = ink;
        px.pixel_valid = 1'b1;
        px.last        = x_major ? (pen_x == goal_x) : (pen_y == goal_y);
        if (px.last) drawing = 1'b0;
        return px;
    endfunction

    function automatic t_in_item request_of(t_command cmd, int sx, int sy, int ex, int ey,
                                            int col);
        t_in_item r;
        r = '0;
        r.command = cmd;
        r.start_x = COORD_BITS'(sx);
        r.start_y = COORD_BITS'(sy);
        r.end_x   = COORD_BITS'(ex);
        r.end_y   = COORD_BITS'(ey);
        r.color   = COLOR_BITS'(col);
        return r;
    endfunction

    function automatic t_out_item pixel_of(int x, int y, int col, bit v, bit l);
        t_out_item p;
        p.pixel_x     = COORD_BITS'(x);
        p.pixel_y     = COORD_BITS'(y);
        p.pixel_color = COLOR_BITS'(col);
        p.pixel_valid = v;
        p.last        = l;
        return p;
    endfunction

    function automatic t_in_item random_request();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
    endfunction

    // coordinate within span of base, mirrored back when it leaves the range
    function automatic int near_coord(int base, int span);
        int v;
        v = base + int'($urandom_range(0, 2 * span)) - span;
        if (v > COORD_MAX || v < COORD_MIN) v = 2 * base - v;
        return v;
    endfunction

    // present one request and hold it until taken
    task automatic send_request(t_in_item req, bit typed, t_out_item px);
        while (int'($urandom_range(0, 99)) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        note_queue.push_back({typed, px});
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        sent_cnt++;
    endtask

    // hold off the sender until every pending pixel has come out
    task automatic drain_pixels();
        in_valid <= 1'b0;
        do @(posedge clk); while (pixel_queue.size() != 0);
    endtask

    task automatic send_line(int x1, int y1, int x2, int y2, int n_steps);
        t_in_item r;
        r = random_request();
        r.command = CMD_START;
        r.start_x = COORD_BITS'(x1);
        r.start_y = COORD_BITS'(y1);
        r.end_x   = COORD_BITS'(x2);
        r.end_y   = COORD_BITS'(y2);
        send_request(r, 1'b0, NO_PIXEL);
        repeat (n_steps) begin
            r = random_request();
            r.command = CMD_STEP;
            send_request(r, 1'b0, NO_PIXEL);
        end
    endtask

    // receiver back-pressure
    always @(posedge clk) begin
        out_ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
    end

    // accepted requests feed the predictor
    always @(posedge clk) begin
        t_note     note;
        t_out_item px;
        if (rst_n && in_valid && in_ready) begin
            px = predict_pixel(in_data);
            note = note_queue.pop_front();
            pixel_queue.push_back(note.typed ? note.px : px);
            if (in_data.command == CMD_START) start_cnt++;
            else step_cnt++;
        end
    end

    // pixel checker
    always @(posedge clk) begin
        t_out_item exp_px;
        if (rst_n && out_valid && out_ready) begin
            if (pixel_queue.size() == 0) begin
                $error("pixel with no request pending: %h", out_data);
                fail_cnt++;
            end else begin
                exp_px = pixel_queue.pop_front();
                checked_cnt++;
                if (!exp_px.pixel_valid) blank_cnt++;
                if (exp_px.last) last_cnt++;
                if (out_data.pixel_x !== exp_px.pixel_x) begin
                    $error("pixel_x: expected %0d, got %0d", exp_px.pixel_x, out_data.pixel_x);
                    fail_cnt++;
                end
                if (out_data.pixel_y !== exp_px.pixel_y) begin
                    $error("pixel_y: expected %0d, got %0d", exp_px.pixel_y, out_data.pixel_y);
                    fail_cnt++;
                end
                if (out_data.pixel_color !== exp_px.pixel_color) begin
                    $error("pixel_color: expected %h, got %h", exp_px.pixel_color,
                           out_data.pixel_color);
                    fail_cnt++;
                end
                if (out_data.pixel_valid !== exp_px.pixel_valid) begin
                    $error("pixel_valid: expected %b, got %b", exp_px.pixel_valid,
                           out_data.pixel_valid);
                    fail_cnt++;
                end
                if (out_data.last !== exp_px.last) begin
                    $error("last: expected %b, got %b", exp_px.last, out_data.last);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_plan_row plan[25];
        int x1, y1, x2, y2, len, n, pick, target;

        // directed rows: idle step, single point, reversed axis lines,
        // full-range diagonals, abandoned lines and a steep line
        plan[0]  = {request_of(CMD_STEP, 0, 0, 0, 0, 0), 1'b1, NO_PIXEL};
        plan[1]  = {request_of(CMD_START, 5, -7, 5, -7, 'hFFFF), 1'b1,
                    pixel_of(5, -7, 'hFFFF, 1, 1)};
        plan[2]  = {request_of(CMD_STEP, -1, -1, -1, -1, 'hFFFF), 1'b1, NO_PIXEL};
        plan[3]  = {request_of(CMD_START, 10, 3, 2, 3, 'h1234), 1'b1,
                    pixel_of(2, 3, 'h1234, 1, 0)};
        for (int i = 4; i < 13; i++)
            plan[i] = {request_of(CMD_STEP, 0, 0, 0, 0, 0), 1'b0, NO_PIXEL};
        plan[13] = {request_of(CMD_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0),
                    1'b1, pixel_of(COORD_MIN, COORD_MIN, 0, 1, 0)};
        plan[14] = {request_of(CMD_STEP, 0, 0, 0, 0, 0), 1'b0, NO_PIXEL};
        plan[15] = plan[14];
        plan[16] = {request_of(CMD_START, 0, COORD_MAX, 0, 2040, 'h0F0F), 1'b1,
                    pixel_of(0, 2040, 'h0F0F, 1, 0)};
        plan[17] = plan[14];
        plan[18] = {request_of(CMD_START, 1, 1, 4, -8, 'h5555), 1'b0, NO_PIXEL};
        plan[19] = plan[14];
        plan[20] = plan[14];
        plan[21] = plan[14];
        plan[22] = {request_of(CMD_START, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 'h8000),
                    1'b1, pixel_of(COORD_MAX, COORD_MIN, 'h8000, 1, 0)};
        plan[23] = plan[14];
        plan[24] = plan[14];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) send_request(plan[i].req, plan[i].typed, plan[i].px);
        drain_pixels();

        // random phases with different idle and stall mixes
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            target = sent_cnt + PHASE_ITEMS;
            while (sent_cnt < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    // short line, mostly walked to its end
                    x1 = any_coord();
                    y1 = any_coord();
                    x2 = near_coord(x1, 20);
                    y2 = near_coord(y1, 20);
                    n = $urandom_range(0, 9);
                    if (n < 2) y2 = y1;
                    else if (n < 4) x2 = x1;
                    len = (x2 > x1 ? x2 - x1 : x1 - x2);
                    if ((y2 > y1 ? y2 - y1 : y1 - y2) > len) len = (y2 > y1 ? y2 - y1 : y1 - y2);
                    n = $urandom_range(0, 99);
                    if (n < 15) len = $urandom_range(0, len);
                    else if (n < 35) len += $urandom_range(1, 2);
                    send_line(x1, y1, x2, y2, len);
                end else if (pick < 80) begin
                    // long line over the full range, abandoned early
                    send_line(any_coord(), any_coord(), any_coord(), any_coord(),
                              $urandom_range(0, 40));
                end else if (pick < 90) begin
                    // point
                    x1 = any_coord();
                    y1 = any_coord();
                    send_line(x1, y1, x1, y1, $urandom_range(0, 2));
                end else begin
                    // stray requests with random content
                    repeat ($urandom_range(1, 3)) send_request(random_request(), 1'b0, NO_PIXEL);
                end
            end
            drain_pixels();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("checked %0d pixels from %0d starts and %0d steps", checked_cnt, start_cnt,
                 step_cnt);
        $display("%0d line ends, %0d steps with no line, %0d mismatches", last_cnt, blank_cnt,
                 fail_cnt);
        if (fail_cnt == 0 && pixel_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
